### rtl/wfs_pkg.sv
`timescale 1ns / 1ps

package wfs_pkg;

    localparam int SAMPLE_W = 8;
    localparam int COEF_W   = 8;
    localparam int WLEN_W   = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTHING_COEF = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH  = 2'd1;

    localparam logic [COEF_W-1:0] COEF_RESET = 8'd128;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd8;

    localparam logic [SAMPLE_W-1:0] SMOOTHED_MAX = 8'd255;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    // start: clear the accumulator and seed the weight
    // step:  fold one sample in and decay the weight
    typedef struct packed {
        logic start;
        logic step;
    } t_mac_ctl;

endpackage

### rtl/wfs_cell.sv
`timescale 1ns / 1ps

module wfs_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic [wfs_pkg::SAMPLE_W-1:0] i_d,
    output logic [wfs_pkg::SAMPLE_W-1:0] o_q
);

    logic [wfs_pkg::SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

### rtl/wfs_mac.sv
`timescale 1ns / 1ps

module wfs_mac #(
    parameter int WEIGHT_FRACTION_BITS = 16,
    parameter int ACC_W                = 28
) (
    input  logic                         i_clk,
    input  wfs_pkg::t_mac_ctl            i_ctl,
    input  logic [wfs_pkg::COEF_W-1:0]   i_coef,
    input  logic [wfs_pkg::SAMPLE_W-1:0] i_sample,
    output logic [ACC_W-1:0]             o_acc
);

    localparam int F      = WEIGHT_FRACTION_BITS;
    localparam int KEEP_W = wfs_pkg::COEF_W + 1;

    logic [F-1:0]                     r_weight;
    logic [F-1:0]                     n_weight;
    logic [ACC_W-1:0]                 r_acc;
    logic [ACC_W-1:0]                 n_acc;
    logic [KEEP_W-1:0]                r_keep;
    logic [F+KEEP_W-1:0]              w_decay;
    logic [F+wfs_pkg::SAMPLE_W-1:0]   w_prod;

    assign w_prod  = i_sample * r_weight;
    assign w_decay = r_weight * r_keep;

    always_comb begin
        n_weight = r_weight;
        n_acc    = r_acc;
        if (i_ctl.start) begin
            n_weight = F'(i_coef) << (F - wfs_pkg::COEF_W);
            n_acc    = '0;
        end else if (i_ctl.step) begin
            // drop eight fraction bits of the Q1.8 keep factor
            n_weight = w_decay[F+7:8];
            n_acc    = r_acc + ACC_W'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_weight <= n_weight;
        r_acc    <= n_acc;
        if (i_ctl.start) begin
            r_keep <= KEEP_W'(9'd256) - KEEP_W'(i_coef);
        end
    end

    assign o_acc = r_acc;

endmodule

### rtl/windowed_exponential_smoother.sv
`timescale 1ns / 1ps
// Each accepted input word is worked through one full rotation of the sample cell
// row past the single multiply-accumulate unit, then waits in a finish state until
// the output register is free; no new word is accepted until that pass is done.
// Reset (synchronous, active low): samples zero, coefficient 128, window 8,
// output empty.

module windowed_exponential_smoother #(
    parameter int MAX_WINDOW           = 16,
    parameter int WEIGHT_FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream, tdata[7:0] = sample
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,
    // output stream, tdata[7:0] = smoothed
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [wfs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [wfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int F     = WEIGHT_FRACTION_BITS;
    localparam int CNT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    // every weight is below 2^F, so the sum stays under MAX_WINDOW * 2^(F+8)
    localparam int ACC_W = F + wfs_pkg::SAMPLE_W + LEN_W;
    localparam int HI_W  = ACC_W - F;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_WINDOW - 1);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [wfs_pkg::COEF_W-1:0] r_coef;
    logic [wfs_pkg::WLEN_W-1:0] r_wlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= wfs_pkg::COEF_RESET;
            r_wlen <= wfs_pkg::WLEN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                wfs_pkg::REG_SMOOTHING_COEF: r_coef <= i_cfg_wdata[wfs_pkg::COEF_W-1:0];
                wfs_pkg::REG_WINDOW_LENGTH:  r_wlen <= i_cfg_wdata[wfs_pkg::WLEN_W-1:0];
                default: ;  // ignore writes past the register list
            endcase
        end
    end

    // Clamp the window into 1..MAX_WINDOW; zero behaves as one sample.
    logic [LEN_W-1:0] w_len;

    always_comb begin
        if (r_wlen == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_wlen) > 32'(MAX_WINDOW)) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = LEN_W'(r_wlen);
        end
    end

    // ---------------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------------
    wfs_pkg::t_state r_state;
    wfs_pkg::t_state n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             w_accept;
    logic             w_run;
    logic             w_load;
    logic             r_out_valid;
    logic [7:0]       r_out_data;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            wfs_pkg::S_IDLE: if (w_accept) n_state = wfs_pkg::S_RUN;
            wfs_pkg::S_RUN:  if (r_cnt == CNT_LAST) n_state = wfs_pkg::S_FIN;
            wfs_pkg::S_FIN:  if (!r_out_valid || m_axis_tready) n_state = wfs_pkg::S_IDLE;
            default:         n_state = wfs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_run         = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            wfs_pkg::S_IDLE: s_axis_tready = 1'b1;
            wfs_pkg::S_RUN:  w_run = 1'b1;
            wfs_pkg::S_FIN:  w_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wfs_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            // advance the step count through one full rotation of the row
            if (w_accept || (w_run && r_cnt == CNT_LAST)) begin
                r_cnt <= '0;
            end else if (w_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sample cell row: cell k holds the sample of age k while idle.
    // An accepted word pushes in at cell 0 and drops the oldest off the end.
    // While running, the row rotates toward cell 0 once per cycle (cell 0
    // wraps to the far end), so cell 0 shows age k at step k; after
    // MAX_WINDOW rotations it is back in age order.
    // ---------------------------------------------------------------------
    logic [wfs_pkg::SAMPLE_W-1:0] w_cell_q [MAX_WINDOW];
    logic                         w_shift;

    assign w_shift = w_accept || w_run;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic [wfs_pkg::SAMPLE_W-1:0] w_d;

        if (g == 0) begin : g_head
            assign w_d = w_accept ? s_axis_tdata : w_cell_q[(g + 1) % MAX_WINDOW];
        end else begin : g_body
            assign w_d = w_accept ? w_cell_q[g-1] : w_cell_q[(g + 1) % MAX_WINDOW];
        end

        wfs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_d),
            .o_q     (w_cell_q[g])
        );
    end

    // ---------------------------------------------------------------------
    // Multiply-accumulate: fold in only the first window-length ages
    // ---------------------------------------------------------------------
    wfs_pkg::t_mac_ctl w_mac_ctl;
    logic [ACC_W-1:0]  w_acc;

    assign w_mac_ctl.start = w_accept;
    assign w_mac_ctl.step  = w_run && (LEN_W'(r_cnt) < w_len);

    wfs_mac #(
        .WEIGHT_FRACTION_BITS (F),
        .ACC_W                (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_mac_ctl),
        .i_coef   (r_coef),
        .i_sample (w_cell_q[0]),
        .o_acc    (w_acc)
    );

    // ---------------------------------------------------------------------
    // Result: integer part plus one, saturated; held in the output register
    // ---------------------------------------------------------------------
    logic [HI_W-1:0] w_hi;
    logic [7:0]      w_result;

    assign w_hi = w_acc[ACC_W-1:F];

    always_comb begin
        if (w_hi >= HI_W'(wfs_pkg::SMOOTHED_MAX)) begin
            w_result = wfs_pkg::SMOOTHED_MAX;
        end else begin
            w_result = w_hi[7:0] + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### rtl/wfs_checker.sv
`timescale 1ns / 1ps

module wfs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [7:0]                     m_axis_tdata
);

    // an accepted word starts work, so the input side closes next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after a word was accepted");

    // a new result only appears at the end of a work pass
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a work pass");

    // plus one is added below saturation and saturation gives 255, so a result is never zero
    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata != 8'd0)
        else $error("zero result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

endmodule

bind windowed_exponential_smoother wfs_checker u_wfs_checker (.*);
